// ===== rtl/core/wenc_pkg.sv =====
package wenc_pkg;

  localparam int CMD_W = 2;
  localparam int CNT_W = 32;
  localparam int VAL_W = 64;
  localparam int CLK_W = 30;
  localparam int Q_BITS = 32;
  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [VAL_W-1:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [VAL_W-1:0] NS_PER_SEC_Q32 = NS_PER_SEC << Q_BITS;
  localparam logic [CLK_W-1:0] CLK_HZ_RESET = 30'd216000000;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ_NS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_RT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_FIN,
    S_MUL_NS,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/wenc_if.sv =====
interface wenc_req_if import wenc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [CNT_W-1:0] cycle_count;

  modport source(output valid, output command, output cycle_count, input ready);
  modport sink(input valid, input command, input cycle_count, output ready);
endinterface

interface wenc_rsp_if import wenc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             armed;

  modport source(output valid, output value, output armed, input ready);
  modport sink(input valid, input value, input armed, output ready);
endinterface

interface wenc_cfg_if import wenc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CLK_W-1:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/wrap_extended_nanosecond_clock_core.sv =====
// Extends a free-running 32-bit cycle counter into a 64-bit nanosecond clock
// and a 64-bit runtime cycle total. Commands: tick (0) folds the counter
// delta into the totals and, the first time, arms the clock by dividing
// 1e9<<32 by the counter frequency; read ns (1) and read runtime (2) each
// return one result with the current armed flag; command 3 is ignored.
// One item is in work at a time and req.ready is low meanwhile. Armed ticks
// and armed ns reads go through a shared 32x32 multiplier used twice; the
// arming tick and an unarmed ns read go through the 64-step bit-serial
// divider. A result waits in an output register while the next item is
// taken. cfg is always ready and should be written only while the block is
// idle; a new frequency after arming is kept but never used, since reset
// restores the reset frequency.
module wrap_extended_nanosecond_clock_core import wenc_pkg::*; (
  input  logic clk,
  input  logic rst,
  wenc_cfg_if.sink   cfg,
  wenc_req_if.sink   req,
  wenc_rsp_if.source rsp
);

  state_t state, state_next;

  logic [CLK_W-1:0] clk_hz;
  logic             is_armed;
  logic [VAL_W-1:0] q;
  logic [VAL_W-1:0] epoch_ns;
  logic [CNT_W-1:0] epoch_cycle;
  logic [VAL_W-1:0] run_total;
  logic [CNT_W-1:0] run_last;
  logic [CMD_W-1:0] cmd;
  logic [CNT_W-1:0] now;
  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] res;

  logic             req_xfer;
  logic [CNT_W-1:0] run_delta;
  logic [CNT_W-1:0] mul_a;
  logic [CNT_W-1:0] mul_b;
  logic [VAL_W-1:0] prod;
  logic [VAL_W-1:0] dividend;
  logic [VAL_W-1:0] quotient;
  logic             div_start;
  logic             div_done;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign run_delta = req.cycle_count - run_last;

  always_comb begin
    mul_a = now - epoch_cycle;
    mul_b = q[CNT_W-1:0];
    unique case (state)
      S_MUL_HI: mul_b = q[VAL_W-1:CNT_W];
      S_MUL_NS: begin
        mul_a = now;
        mul_b = NS_PER_SEC[CNT_W-1:0];
      end
      default: ;
    endcase
  end

  assign dividend  = (cmd == CMD_TICK) ? NS_PER_SEC_Q32 : prod;
  assign div_start = (state == S_DIV_GO);

  wenc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  wenc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (clk_hz),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          case (req.command)
            CMD_TICK:    state_next = is_armed ? S_MUL_LO : S_DIV_GO;
            CMD_READ_NS: state_next = is_armed ? S_MUL_LO : S_MUL_NS;
            CMD_READ_RT: state_next = S_DONE;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_MUL_LO:   state_next = S_MUL_HI;
      S_MUL_HI:   state_next = S_SUM;
      S_SUM:      state_next = S_FIN;
      S_FIN:      state_next = (cmd == CMD_TICK) ? S_IDLE : S_DONE;
      S_MUL_NS:   state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = (cmd == CMD_TICK) ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz      <= CLK_HZ_RESET;
      is_armed    <= 1'b0;
      q           <= '0;
      epoch_ns    <= '0;
      epoch_cycle <= '0;
      run_total   <= '0;
      run_last    <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        clk_hz <= cfg.data;
      end
      if (req_xfer && req.command == CMD_TICK) begin
        run_total <= run_total + VAL_W'(run_delta);
        run_last  <= req.cycle_count;
      end
      if (state == S_FIN && cmd == CMD_TICK) begin
        epoch_ns    <= epoch_ns + acc;
        epoch_cycle <= now;
      end
      if (state == S_DIV_WAIT && div_done && cmd == CMD_TICK) begin
        q           <= quotient;
        epoch_cycle <= now;
        is_armed    <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cmd <= req.command;
      now <= req.cycle_count;
      res <= run_total + VAL_W'(run_delta);
    end
    case (state)
      S_MUL_HI: acc <= VAL_W'(prod[VAL_W-1:Q_BITS]);
      S_SUM:    acc <= prod + acc;
      S_FIN:    res <= epoch_ns + acc;
      S_DIV_WAIT: begin
        if (div_done) begin
          res <= quotient;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.value <= res;
      rsp.armed <= is_armed;
    end
  end

endmodule

// ===== rtl/core/wenc_div.sv =====
module wenc_div import wenc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [CLK_W-1:0] divisor,
  output logic             done,
  output logic [VAL_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CLK_W-1:0]     den;
  logic [CLK_W-1:0]     rem;
  logic [VAL_W-1:0]     quo;
  logic [CLK_W:0]       trial;
  logic [CLK_W:0]       diff;
  logic                 fits;

  // restoring division, one quotient bit per cycle; zero divisor gives all ones
  assign trial = {rem, quo[VAL_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        den  <= divisor;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
        quo <= {quo[VAL_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/core/wenc_mul.sv =====
module wenc_mul import wenc_pkg::*; (
  input  logic             clk,
  input  logic [CNT_W-1:0] a,
  input  logic [CNT_W-1:0] b,
  output logic [VAL_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= VAL_W'(a) * VAL_W'(b);
  end

endmodule

// ===== bench/wrap_extended_nanosecond_clock_core_tb.sv =====
module wrap_extended_nanosecond_clock_core_tb;
  import wenc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] NSEC = 64'd1000000000;
  localparam logic [CLK_W-1:0] HZ_RESET = 30'd216000000;
  localparam logic [CLK_W-1:0] HZ_MAX = '1;
  localparam logic [CLK_W-1:0] HZ_1MHZ = 30'd1000000;
  localparam logic [CLK_W-1:0] HZ_1GHZ = 30'd1000000000;
  localparam int IDLE_PCT = 27;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 350;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] cnt;
  } clk_cmd_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             armed;
  } clk_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wenc_cfg_if cfg_bus ();
  wenc_req_if req_bus ();
  wenc_rsp_if rsp_bus ();

  wrap_extended_nanosecond_clock_core dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  clk_cmd_t    clock_cmds[$];
  clk_result_t expected_readings[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  logic        req_done = 1'b0;
  logic        no_gap = 1'b0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;

  // timekeeping state mirrored from the block
  logic [CLK_W-1:0] hz_shadow = HZ_RESET;
  logic             armed_shadow = 1'b0;
  logic [VAL_W-1:0] recip_shadow = '0;
  logic [VAL_W-1:0] epoch_ns_shadow = '0;
  logic [CNT_W-1:0] epoch_cyc_shadow = '0;
  logic [VAL_W-1:0] runtime_shadow = '0;
  logic [CNT_W-1:0] runtime_last_shadow = '0;

  function automatic logic [VAL_W-1:0] div_or_ones(logic [VAL_W-1:0] num,
                                                   logic [CLK_W-1:0] den);
    logic [VAL_W-1:0] den_w;
    den_w = {{(VAL_W-CLK_W){1'b0}}, den};
    if (den == '0) return '1;
    return num / den_w;
  endfunction

  // (delta * q) >> 32 from the full 96-bit product, wrapped to 64 bits
  function automatic logic [VAL_W-1:0] scale_ns(logic [CNT_W-1:0] delta,
                                                logic [VAL_W-1:0] q);
    logic [95:0] prod;
    prod = {64'd0, delta} * {32'd0, q};
    return prod[95:32];
  endfunction

  task automatic advance_clock(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] now);
    logic [CNT_W-1:0] d_run;
    logic [CNT_W-1:0] d_epoch;
    clk_result_t      r;
    d_run = now - runtime_last_shadow;
    d_epoch = now - epoch_cyc_shadow;
    case (cmd)
      CMD_TICK: begin
        runtime_shadow = runtime_shadow + {32'd0, d_run};
        runtime_last_shadow = now;
        if (!armed_shadow) begin
          recip_shadow = div_or_ones(NSEC << Q_BITS, hz_shadow);
          armed_shadow = 1'b1;
        end else begin
          epoch_ns_shadow = epoch_ns_shadow + scale_ns(d_epoch, recip_shadow);
        end
        epoch_cyc_shadow = now;
      end
      CMD_READ_NS: begin
        if (armed_shadow) r.value = epoch_ns_shadow + scale_ns(d_epoch, recip_shadow);
        else r.value = div_or_ones({32'd0, now} * NSEC, hz_shadow);
        r.armed = armed_shadow;
        expected_readings.push_back(r);
      end
      CMD_READ_RT: begin
        r.value = runtime_shadow + {32'd0, d_run};
        r.armed = armed_shadow;
        expected_readings.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_done) begin
      if (clock_cmds.size() > 0 && (no_gap || $urandom_range(99) >= IDLE_PCT)) begin
        req_bus.valid <= 1'b1;
        req_bus.command <= clock_cmds[0].cmd;
        req_bus.cycle_count <= clock_cmds[0].cnt;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= no_gap || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : monitor
    clk_result_t exp_r;
    logic        moved;
    moved = 1'b0;
    req_done <= req_bus.valid && req_bus.ready;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        hz_shadow = cfg_bus.data;
        moved = 1'b1;
      end
      if (req_bus.valid && req_bus.ready) begin
        advance_clock(req_bus.command, req_bus.cycle_count);
        void'(clock_cmds.pop_front());
        moved = 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        moved = 1'b1;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %h armed %b",
                   $time, rsp_bus.value, rsp_bus.armed);
          errors++;
        end else begin
          exp_r = expected_readings.pop_front();
          if (rsp_bus.value !== exp_r.value) begin
            $display("%0t: value mismatch, expected %h, actual %h",
                     $time, exp_r.value, rsp_bus.value);
            errors++;
          end
          if (rsp_bus.armed !== exp_r.armed) begin
            $display("%0t: armed mismatch, expected %b, actual %b",
                     $time, exp_r.armed, rsp_bus.armed);
            errors++;
          end
        end
      end
    end
    if (moved) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("** wrap_extended_nanosecond_clock_core: FAILED **");
      $finish;
    end
  end

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] cnt);
    clk_cmd_t t;
    t.cmd = cmd;
    t.cnt = cnt;
    clock_cmds.push_back(t);
  endtask

  // sender pause: wait for all readings, then let a trailing tick finish
  task automatic drain;
    while (clock_cmds.size() > 0 || expected_readings.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_clock(input logic [CLK_W-1:0] hz);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= hz;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [CNT_W-1:0] next_count(logic [CNT_W-1:0] c);
    case ($urandom_range(9))
      0: return $urandom;
      1: return c - $urandom_range(1000);
      2: return c + $urandom;
      3: return c;
      default: return c + $urandom_range(1, 300000);
    endcase
  endfunction

  initial begin : stimulus
    logic [CNT_W-1:0] c;
    logic [CLK_W-1:0] arm_hz;
    logic [CLK_W-1:0] phase_hz[5];
    logic [CMD_W-1:0] cmd;
    int               n;
    int               r;
    req_bus.valid = 1'b0;
    req_bus.command = CMD_TICK;
    req_bus.cycle_count = '0;
    rsp_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unarmed: ns reads scale the raw count, under several frequencies
    add_cmd(CMD_READ_NS, '0);
    add_cmd(CMD_READ_NS, '1);
    add_cmd(CMD_READ_RT, '1);
    add_cmd(CMD_READ_RT, '0);
    add_cmd(CMD_UNUSED, '1);
    add_cmd(CMD_UNUSED, '0);
    drain();
    set_clock('0);
    add_cmd(CMD_READ_NS, 32'h1234_5678);
    add_cmd(CMD_READ_NS, '1);
    drain();
    set_clock(HZ_MAX);
    add_cmd(CMD_READ_NS, '1);
    add_cmd(CMD_READ_NS, 32'd1);
    drain();
    set_clock(HZ_1MHZ);
    add_cmd(CMD_READ_NS, '1);
    drain();
    set_clock(HZ_1GHZ);
    add_cmd(CMD_READ_NS, '1);
    add_cmd(CMD_READ_RT, 32'h8000_0000);
    drain();

    // arming happens once per run; the frequency used for it is drawn here
    case ($urandom_range(5))
      0: arm_hz = '0;
      1: arm_hz = HZ_MAX;
      2: arm_hz = HZ_1MHZ;
      3: arm_hz = HZ_1GHZ;
      4: arm_hz = HZ_RESET;
      default: arm_hz = CLK_W'($urandom_range(1000000, 1000000000));
    endcase
    set_clock(arm_hz);
    c = $urandom;
    add_cmd(CMD_TICK, c);
    add_cmd(CMD_READ_NS, c);
    add_cmd(CMD_READ_NS, c - 1);
    add_cmd(CMD_READ_RT, c + 5);
    add_cmd(CMD_TICK, c);
    add_cmd(CMD_TICK, c - 1);
    add_cmd(CMD_TICK, '1);
    add_cmd(CMD_TICK, 32'd5);
    add_cmd(CMD_READ_NS, 32'd9);
    add_cmd(CMD_READ_RT, 32'd9);
    add_cmd(CMD_UNUSED, '0);
    c = 32'd9;

    // armed: frequency changes must not disturb the kept reciprocal
    phase_hz[0] = '0;
    phase_hz[1] = HZ_MAX;
    phase_hz[2] = HZ_1MHZ;
    phase_hz[3] = HZ_1GHZ;
    phase_hz[4] = CLK_W'($urandom_range(1000000, 1000000000));
    for (int p = 0; p < 5; p++) begin
      drain();
      set_clock(phase_hz[p]);
      no_gap = (p == 2);
      if (p == 0) hold_req = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 40) cmd = CMD_TICK;
        else if (r < 70) cmd = CMD_READ_NS;
        else if (r < 95) cmd = CMD_READ_RT;
        else cmd = CMD_UNUSED;
        c = next_count(c);
        add_cmd(cmd, c);
        if (cmd != CMD_UNUSED) n++;
      end
    end
    drain();
    no_gap = 1'b0;

    if (errors == 0) begin
      $display("** wrap_extended_nanosecond_clock_core: PASSED **");
    end else begin
      $display("** wrap_extended_nanosecond_clock_core: FAILED **");
    end
    $finish;
  end

endmodule
